### design/gamr_pkg.sv
`timescale 1ns / 1ps

package gamr_pkg;

	localparam int TIMESTAMP_WIDTH = 32;

	localparam int LEVEL_W = 12;
	localparam int DEADZONE_W = 15;
	localparam int GAIN_W = 16;
	localparam int RATE_W = 16;
	localparam int MOVE_W = 8;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_INDEX_W = 2;

	localparam int SAT_LIMIT = 127;
	localparam int HOLD_LONG_MS = 400;
	localparam int HOLD_SHORT_MS = 80;
	localparam int REFRACTORY_MS = 250;
	localparam int SCROLL_DIV = 20;
	localparam int GAIN_FRAC_BITS = 8;

	// pitch magnitude at or above which the wheel saturates
	localparam int SCROLL_SAT_MAG = SAT_LIMIT * SCROLL_DIV;
	// reciprocal of the wheel divider, exact for magnitudes below the saturation point
	localparam int SCROLL_RECIP_SHIFT = 16;
	localparam int SCROLL_RECIP = ((1 << SCROLL_RECIP_SHIFT) + SCROLL_DIV - 1) / SCROLL_DIV;
	localparam int SCROLL_MAG_W = 12;

	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);

	typedef enum logic [1:0] {
		MUSCLE_REST  = 2'd0,
		MUSCLE_FLEX  = 2'd1,
		MUSCLE_EXT   = 2'd2,
		MUSCLE_OTHER = 2'd3
	} muscle_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_CLUTCH_LOW  = 2'd0,
		CFG_CLUTCH_HIGH = 2'd1,
		CFG_DEADZONE    = 2'd2,
		CFG_GAIN        = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic left;
		logic right;
		logic scrolling;
	} gest_t;

endpackage

### design/gesture_air_mouse_reporter.sv
`timescale 1ns / 1ps

// Gesture air-mouse reporter: one mouse report per sensor frame. A frame is
// captured in an input register, from which the logic computes cursor deltas
// (deadzone, Q8.8 gain, saturation to +-127), the wheel delta and the button
// state in one pass; the hold timers and click history update as the report
// is loaded into an output register, where it sits until taken. A new frame
// can be taken every cycle while the output is not stalled. Timestamps are
// reduced to TIMESTAMP_WIDTH bits and all hold durations wrap at that width.
// Configuration registers are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while no frame is in flight, which the block
// itself does not enforce.
module gesture_air_mouse_reporter #(
	parameter int TIMESTAMP_WIDTH = gamr_pkg::TIMESTAMP_WIDTH
) (
	input  logic                                    clk,
	input  logic                                    arst_n,

	input  logic                                    cfg_we,
	input  logic        [gamr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic        [gamr_pkg::CFG_DATA_W-1:0]  cfg_data,

	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic        [1:0]                       intent,
	input  logic        [31:0]                      time_ms,
	input  logic        [gamr_pkg::LEVEL_W-1:0]     flexor_level,
	input  logic signed [gamr_pkg::RATE_W-1:0]      yaw_rate,
	input  logic signed [gamr_pkg::RATE_W-1:0]      pitch_rate,

	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [gamr_pkg::MOVE_W-1:0]      move_x,
	output logic signed [gamr_pkg::MOVE_W-1:0]      move_y,
	output logic signed [gamr_pkg::MOVE_W-1:0]      scroll,
	output logic                                    left_button,
	output logic                                    right_button
);

	localparam int TW = TIMESTAMP_WIDTH;
	localparam int MW = gamr_pkg::MOVE_W;
	localparam int SMW = gamr_pkg::SCROLL_MAG_W;
	localparam int RECIP_W = SMW + 2;

	// configuration
	logic [gamr_pkg::LEVEL_W-1:0]    clutch_low_q;
	logic [gamr_pkg::LEVEL_W-1:0]    clutch_high_q;
	logic [gamr_pkg::DEADZONE_W-1:0] deadzone_q;
	logic [gamr_pkg::GAIN_W-1:0]     gain_q;

	// input stage
	logic                              valid_s1;
	gamr_pkg::muscle_t                 intent_s1;
	logic [TW-1:0]                     now_s1;
	logic [gamr_pkg::LEVEL_W-1:0]      flex_s1;
	logic signed [gamr_pkg::RATE_W-1:0] yaw_s1;
	logic signed [gamr_pkg::RATE_W-1:0] pitch_s1;

	// output register
	logic                 out_valid_q;
	logic signed [MW-1:0] move_x_q;
	logic signed [MW-1:0] move_y_q;
	logic signed [MW-1:0] scroll_q;
	logic                 left_q;
	logic                 right_q;

	logic advance;
	logic in_xfer;
	logic step;

	logic signed [gamr_pkg::RATE_W-1:0] dz_yaw;
	logic signed [gamr_pkg::RATE_W-1:0] dz_pitch;
	logic signed [MW-1:0]               scaled_x;
	logic signed [MW-1:0]               scaled_y;
	gamr_pkg::gest_t                    gest;

	logic                              clutch;
	logic signed [gamr_pkg::RATE_W:0]  pitch_ext;
	logic        [gamr_pkg::RATE_W:0]  pitch_mag;
	logic [SMW+RECIP_W-1:0]            recip_prod;
	logic [MW-1:0]                     wheel_mag;
	logic signed [MW-1:0]              wheel;
	logic signed [MW-1:0]              dx;
	logic signed [MW-1:0]              dy;

	assign advance = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_xfer = in_valid && !in_stall;
	assign step = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clutch_low_q <= '0;
			clutch_high_q <= '0;
			deadzone_q <= '0;
			gain_q <= gamr_pkg::GAIN_RESET;
		end else if (cfg_we) begin
			case (gamr_pkg::cfg_index_t'(cfg_index))
				gamr_pkg::CFG_CLUTCH_LOW: clutch_low_q <= cfg_data[gamr_pkg::LEVEL_W-1:0];
				gamr_pkg::CFG_CLUTCH_HIGH: clutch_high_q <= cfg_data[gamr_pkg::LEVEL_W-1:0];
				gamr_pkg::CFG_DEADZONE: deadzone_q <= cfg_data[gamr_pkg::DEADZONE_W-1:0];
				gamr_pkg::CFG_GAIN: gain_q <= cfg_data[gamr_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			intent_s1 <= gamr_pkg::muscle_t'(intent);
			now_s1 <= TW'(time_ms);
			flex_s1 <= flexor_level;
			yaw_s1 <= yaw_rate;
			pitch_s1 <= pitch_rate;
		end
	end

	gamr_axis_scale u_scale_x (
		.rate     (yaw_s1),
		.deadzone (deadzone_q),
		.gain     (gain_q),
		.dz_rate  (dz_yaw),
		.move     (scaled_x)
	);

	gamr_axis_scale u_scale_y (
		.rate     (pitch_s1),
		.deadzone (deadzone_q),
		.gain     (gain_q),
		.dz_rate  (dz_pitch),
		.move     (scaled_y)
	);

	gamr_gesture #(
		.TW (TW)
	) u_gesture (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.intent (intent_s1),
		.now    (now_s1),
		.gest   (gest)
	);

	// wheel = trunc(-pitch / 20), saturated
	always_comb begin
		pitch_ext = (gamr_pkg::RATE_W + 1)'(dz_pitch);
		pitch_mag = pitch_ext[gamr_pkg::RATE_W] ? unsigned'(-pitch_ext) : unsigned'(pitch_ext);
		recip_prod = pitch_mag[SMW-1:0] * RECIP_W'(gamr_pkg::SCROLL_RECIP);
		if (pitch_mag >= (gamr_pkg::RATE_W + 1)'(gamr_pkg::SCROLL_SAT_MAG)) begin
			wheel_mag = MW'(gamr_pkg::SAT_LIMIT);
		end else begin
			wheel_mag = recip_prod[gamr_pkg::SCROLL_RECIP_SHIFT +: MW];
		end
		wheel = pitch_ext[gamr_pkg::RATE_W] ? signed'(wheel_mag) : -signed'(wheel_mag);
	end

	always_comb begin
		clutch = (flex_s1 > clutch_low_q) && (flex_s1 < clutch_high_q);
		dx = clutch ? '0 : scaled_x;
		dy = (clutch || gest.scrolling) ? '0 : scaled_y;
	end

	always_ff @(posedge clk) begin
		if (step) begin
			move_x_q <= dx;
			move_y_q <= dy;
			scroll_q <= gest.scrolling ? wheel : '0;
			left_q <= gest.left;
			right_q <= gest.right;
		end
	end

	assign out_valid = out_valid_q;
	assign move_x = move_x_q;
	assign move_y = move_y_q;
	assign scroll = scroll_q;
	assign left_button = left_q;
	assign right_button = right_q;

endmodule

### design/gamr_axis_scale.sv
`timescale 1ns / 1ps

module gamr_axis_scale (
	input  logic signed [gamr_pkg::RATE_W-1:0]     rate,
	input  logic        [gamr_pkg::DEADZONE_W-1:0] deadzone,
	input  logic        [gamr_pkg::GAIN_W-1:0]     gain,
	output logic signed [gamr_pkg::RATE_W-1:0]     dz_rate,
	output logic signed [gamr_pkg::MOVE_W-1:0]     move
);

	localparam int PROD_W = gamr_pkg::RATE_W + gamr_pkg::GAIN_W + 1;

	logic signed [gamr_pkg::RATE_W:0] rate_ext;
	logic        [gamr_pkg::RATE_W:0] mag;
	logic signed [PROD_W-1:0]         prod;
	logic signed [PROD_W-1:0]         biased;
	logic signed [PROD_W-1:0]         quo;

	always_comb begin
		rate_ext = (gamr_pkg::RATE_W + 1)'(rate);
		mag = rate_ext[gamr_pkg::RATE_W] ? unsigned'(-rate_ext) : unsigned'(rate_ext);
		dz_rate = (mag < (gamr_pkg::RATE_W + 1)'(deadzone)) ? '0 : rate;
		prod = PROD_W'(dz_rate) * PROD_W'(signed'({1'b0, gain}));
		// truncate toward zero
		biased = prod[PROD_W-1]
			? prod + PROD_W'((1 << gamr_pkg::GAIN_FRAC_BITS) - 1) : prod;
		quo = biased >>> gamr_pkg::GAIN_FRAC_BITS;
		if (quo > PROD_W'(gamr_pkg::SAT_LIMIT)) begin
			move = gamr_pkg::MOVE_W'(gamr_pkg::SAT_LIMIT);
		end else if (quo < -PROD_W'(gamr_pkg::SAT_LIMIT)) begin
			move = -gamr_pkg::MOVE_W'(gamr_pkg::SAT_LIMIT);
		end else begin
			move = quo[gamr_pkg::MOVE_W-1:0];
		end
	end

endmodule

### design/gamr_gesture.sv
`timescale 1ns / 1ps

module gamr_gesture #(
	parameter int TW = gamr_pkg::TIMESTAMP_WIDTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  gamr_pkg::muscle_t       intent,
	input  logic [TW-1:0]           now,
	output gamr_pkg::gest_t         gest
);

	logic [TW-1:0] flex_start_q;
	logic [TW-1:0] ext_start_q;
	logic [TW-1:0] prev_click_q;
	logic          drag_q;

	logic [TW-1:0] flex_start_d;
	logic [TW-1:0] ext_start_d;
	logic [TW-1:0] last_mid;
	logic [TW-1:0] prev_click_d;
	logic          drag_d;
	logic [TW-1:0] flex_dur;
	logic [TW-1:0] ext_dur;
	logic          click_l;
	logic          click_r;
	logic          scrolling;

	always_comb begin
		click_l = 1'b0;
		click_r = 1'b0;
		scrolling = 1'b0;
		drag_d = drag_q;
		flex_start_d = flex_start_q;
		ext_start_d = ext_start_q;
		last_mid = prev_click_q;

		if (intent == gamr_pkg::MUSCLE_FLEX) begin
			if (flex_start_q == '0) begin
				flex_start_d = now;
			end
			flex_dur = now - flex_start_d;
			if (flex_dur >= TW'(gamr_pkg::HOLD_LONG_MS)) begin
				drag_d = 1'b1;
			end
		end else begin
			flex_dur = now - flex_start_q;
			if (flex_start_q != '0) begin
				if (!drag_q && flex_dur >= TW'(gamr_pkg::HOLD_SHORT_MS)
						&& (now - prev_click_q) >= TW'(gamr_pkg::REFRACTORY_MS)) begin
					click_l = 1'b1;
					last_mid = now;
				end
				drag_d = 1'b0;
				flex_start_d = '0;
			end
		end

		prev_click_d = last_mid;
		if (intent == gamr_pkg::MUSCLE_EXT) begin
			if (ext_start_q == '0) begin
				ext_start_d = now;
			end
			ext_dur = now - ext_start_d;
			scrolling = ext_dur >= TW'(gamr_pkg::HOLD_LONG_MS);
		end else begin
			ext_dur = now - ext_start_q;
			if (ext_start_q != '0) begin
				if (ext_dur >= TW'(gamr_pkg::HOLD_SHORT_MS)
						&& ext_dur < TW'(gamr_pkg::HOLD_LONG_MS)
						&& (now - last_mid) >= TW'(gamr_pkg::REFRACTORY_MS)) begin
					click_r = 1'b1;
					prev_click_d = now;
				end
				ext_start_d = '0;
			end
		end
	end

	always_comb begin
		gest.left = click_l | drag_d;
		gest.right = click_r;
		gest.scrolling = scrolling;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flex_start_q <= '0;
			ext_start_q <= '0;
			prev_click_q <= '0;
			drag_q <= 1'b0;
		end else if (step) begin
			flex_start_q <= flex_start_d;
			ext_start_q <= ext_start_d;
			prev_click_q <= prev_click_d;
			drag_q <= drag_d;
		end
	end

endmodule

### design/gamr_checker.sv
`timescale 1ns / 1ps

module gamr_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic signed [gamr_pkg::MOVE_W-1:0] move_x,
	input logic signed [gamr_pkg::MOVE_W-1:0] move_y,
	input logic signed [gamr_pkg::MOVE_W-1:0] scroll,
	input logic                               left_button,
	input logic                               right_button
);

	localparam logic [gamr_pkg::MOVE_W-1:0] MOST_NEG = {1'b1, {(gamr_pkg::MOVE_W-1){1'b0}}};

	// a stalled report holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid
			&& $stable({move_x, move_y, scroll, left_button, right_button}))
		else $error("report changed while stalled");

	// input side backs up only behind a stalled report
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with output free");

	// scrolling zeroes vertical motion
	a_scroll_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> move_y == '0 || scroll == '0)
		else $error("move_y and scroll both nonzero");

	// saturation is symmetric
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> move_x != MOST_NEG && move_y != MOST_NEG && scroll != MOST_NEG)
		else $error("delta outside +-127");

endmodule

bind gesture_air_mouse_reporter gamr_checker u_gamr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.move_x       (move_x),
	.move_y       (move_y),
	.scroll       (scroll),
	.left_button  (left_button),
	.right_button (right_button)
);

### test/gesture_air_mouse_reporter_tb.sv
`timescale 1ns / 1ps

module gesture_air_mouse_reporter_tb;

	localparam int STUCK_LIMIT = 3000;
	localparam int PRESSURE_CYCLES = 300;
	localparam int ITEMS_PER_PHASE = 170;

	typedef struct packed {
		logic signed [gamr_pkg::MOVE_W-1:0] mx;
		logic signed [gamr_pkg::MOVE_W-1:0] my;
		logic signed [gamr_pkg::MOVE_W-1:0] sc;
		logic                               lb;
		logic                               rb;
	} report_t;

	typedef struct packed {
		gamr_pkg::muscle_t                  it;
		logic [31:0]                        t;
		logic [gamr_pkg::LEVEL_W-1:0]       fl;
		logic signed [gamr_pkg::RATE_W-1:0] yaw;
		logic signed [gamr_pkg::RATE_W-1:0] pitch;
		logic                               typed;
		report_t                            rep;
	} frame_row_t;

	typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	localparam report_t REP_ZERO  = '{8'sd0, 8'sd0, 8'sd0, 1'b0, 1'b0};
	localparam report_t REP_LEFT  = '{8'sd0, 8'sd0, 8'sd0, 1'b1, 1'b0};
	localparam report_t REP_RIGHT = '{8'sd0, 8'sd0, 8'sd0, 1'b0, 1'b1};

	localparam int N_DIR = 27;
	localparam frame_row_t DIR_ROWS [N_DIR] = '{
		'{gamr_pkg::MUSCLE_REST,  32'd1000, 12'd0,    16'sh7fff, 16'sh8000, 1'b1,
			'{8'sd127, -8'sd127, 8'sd0, 1'b0, 1'b0}},
		'{gamr_pkg::MUSCLE_REST,  32'd1010, 12'd0,    16'sd0,    16'sd0,    1'b1, REP_ZERO},
		'{gamr_pkg::MUSCLE_OTHER, 32'd1020, 12'd4095, -16'sd1,   16'sd1,    1'b1,
			'{-8'sd1, 8'sd1, 8'sd0, 1'b0, 1'b0}},
		'{gamr_pkg::MUSCLE_FLEX,  32'd2000, 12'd0,    16'sd0,    16'sd0,    1'b1, REP_ZERO},
		'{gamr_pkg::MUSCLE_FLEX,  32'd2050, 12'd77,   16'sd300,  -16'sd9,   1'b0, REP_ZERO},
		'{gamr_pkg::MUSCLE_REST,  32'd2100, 12'd0,    16'sd0,    16'sd0,    1'b1, REP_LEFT},
		'{gamr_pkg::MUSCLE_FLEX,  32'd3000, 12'd0,    16'sd0,    16'sd0,    1'b1, REP_ZERO},
		'{gamr_pkg::MUSCLE_REST,  32'd3050, 12'd0,    16'sd0,    16'sd0,    1'b1, REP_ZERO},
		'{gamr_pkg::MUSCLE_FLEX,  32'd4000, 12'd0,    16'sd0,    16'sd0,    1'b1, REP_ZERO},
		'{gamr_pkg::MUSCLE_FLEX,  32'd4400, 12'd0,    16'sd0,    16'sd0,    1'b1, REP_LEFT},
		'{gamr_pkg::MUSCLE_REST,  32'd4500, 12'd0,    16'sd0,    16'sd0,    1'b1, REP_ZERO},
		'{gamr_pkg::MUSCLE_EXT,   32'd5000, 12'd0,    16'sd0,    16'sd0,    1'b1, REP_ZERO},
		'{gamr_pkg::MUSCLE_EXT,   32'd5100, 12'd9,    -16'sd40,  16'sd1234, 1'b0, REP_ZERO},
		'{gamr_pkg::MUSCLE_REST,  32'd5200, 12'd0,    16'sd0,    16'sd0,    1'b1, REP_RIGHT},
		'{gamr_pkg::MUSCLE_EXT,   32'd6000, 12'd0,    16'sd0,    16'sd0,    1'b1, REP_ZERO},
		'{gamr_pkg::MUSCLE_EXT,   32'd6400, 12'd0,    16'sd0,    -16'sd2540, 1'b1,
			'{8'sd0, 8'sd0, 8'sd127, 1'b0, 1'b0}},
		'{gamr_pkg::MUSCLE_EXT,   32'd6500, 12'd0,    16'sd5,    16'sh7fff, 1'b1,
			'{8'sd5, 8'sd0, -8'sd127, 1'b0, 1'b0}},
		'{gamr_pkg::MUSCLE_OTHER, 32'd6600, 12'd0,    16'sd0,    16'sd0,    1'b1, REP_ZERO},
		'{gamr_pkg::MUSCLE_FLEX,  32'd7000, 12'd0,    16'sd0,    16'sd0,    1'b1, REP_ZERO},
		'{gamr_pkg::MUSCLE_REST,  32'd7100, 12'd0,    16'sd0,    16'sd0,    1'b1, REP_LEFT},
		'{gamr_pkg::MUSCLE_FLEX,  32'd7150, 12'd0,    16'sd0,    16'sd0,    1'b1, REP_ZERO},
		'{gamr_pkg::MUSCLE_REST,  32'd7300, 12'd0,    16'sd0,    16'sd0,    1'b1, REP_ZERO},
		'{gamr_pkg::MUSCLE_FLEX,  32'd0,    12'd5,    16'sd17,   -16'sd17,  1'b0, REP_ZERO},
		'{gamr_pkg::MUSCLE_FLEX,  32'd500,  12'd0,    16'sd0,    16'sd0,    1'b0, REP_ZERO},
		'{gamr_pkg::MUSCLE_REST,  32'd600,  12'd0,    16'sd0,    16'sd0,    1'b0, REP_ZERO},
		'{gamr_pkg::MUSCLE_FLEX,  32'hffff_fff0, 12'hfff, 16'sh7fff, 16'sh7fff, 1'b0, REP_ZERO},
		'{gamr_pkg::MUSCLE_REST,  32'h0000_0050, 12'd0, 16'sh8000, 16'sh8000, 1'b0, REP_ZERO}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                             cfg_we = 1'b0;
	logic [gamr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [gamr_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

	logic                               in_valid = 1'b0;
	logic                               in_stall;
	gamr_pkg::muscle_t                  intent = gamr_pkg::MUSCLE_REST;
	logic [31:0]                        time_ms = '0;
	logic [gamr_pkg::LEVEL_W-1:0]       flexor_level = '0;
	logic signed [gamr_pkg::RATE_W-1:0] yaw_rate = '0;
	logic signed [gamr_pkg::RATE_W-1:0] pitch_rate = '0;

	logic                               out_valid;
	logic                               out_stall = 1'b0;
	logic signed [gamr_pkg::MOVE_W-1:0] move_x;
	logic signed [gamr_pkg::MOVE_W-1:0] move_y;
	logic signed [gamr_pkg::MOVE_W-1:0] scroll;
	logic                               left_button;
	logic                               right_button;

	gesture_air_mouse_reporter u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.intent       (intent),
		.time_ms      (time_ms),
		.flexor_level (flexor_level),
		.yaw_rate     (yaw_rate),
		.pitch_rate   (pitch_rate),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.move_x       (move_x),
		.move_y       (move_y),
		.scroll       (scroll),
		.left_button  (left_button),
		.right_button (right_button)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mirrored registers and gesture state
	logic [gamr_pkg::LEVEL_W-1:0]    clutch_lo = '0;
	logic [gamr_pkg::LEVEL_W-1:0]    clutch_hi = '0;
	logic [gamr_pkg::DEADZONE_W-1:0] dz_level = '0;
	logic [gamr_pkg::GAIN_W-1:0]     gain = gamr_pkg::GAIN_RESET;
	logic [31:0]                     flex_start = '0;
	logic [31:0]                     ext_start = '0;
	logic [31:0]                     prev_click = '0;
	logic                            drag_on = 1'b0;

	report_t           report_q[$];
	int                fail_count = 0;
	int                stuck_cycles = 0;
	idle_mode_t        idle_mode = IDLE_NONE;
	logic              pressure_req = 1'b0;
	logic              pressure_done = 1'b0;
	int                hold_cnt = 0;
	logic [31:0]       stream_time = 32'd100;
	gamr_pkg::muscle_t stream_intent = gamr_pkg::MUSCLE_REST;

	function automatic longint clip127(longint v);
		if (v > gamr_pkg::SAT_LIMIT)
			return gamr_pkg::SAT_LIMIT;
		if (v < -gamr_pkg::SAT_LIMIT)
			return -gamr_pkg::SAT_LIMIT;
		return v;
	endfunction

	function automatic longint dz_rate(logic signed [gamr_pkg::RATE_W-1:0] r);
		longint v;
		longint mag;
		v = r;
		mag = (v < 0) ? -v : v;
		return (mag < longint'(dz_level)) ? 0 : v;
	endfunction

	function automatic longint gain_scale(longint v);
		return clip127((v * longint'(gain)) / 256);
	endfunction

	function automatic report_t predict_report(gamr_pkg::muscle_t it, logic [31:0] now,
			logic [gamr_pkg::LEVEL_W-1:0] fl, logic signed [gamr_pkg::RATE_W-1:0] yaw,
			logic signed [gamr_pkg::RATE_W-1:0] pitch);
		longint ax, ay, dx, dy, wheel;
		logic clutch, lb, rb;
		logic [31:0] held, since_click;
		report_t rep;
		ax = dz_rate(yaw);
		ay = dz_rate(pitch);
		clutch = (fl > clutch_lo) && (fl < clutch_hi);
		dx = clutch ? 0 : gain_scale(ax);
		dy = clutch ? 0 : gain_scale(ay);
		wheel = 0;
		lb = 1'b0;
		rb = 1'b0;

		if (it == gamr_pkg::MUSCLE_FLEX) begin
			if (flex_start == 0)
				flex_start = now;
			held = now - flex_start;
			if (held >= 32'(gamr_pkg::HOLD_LONG_MS))
				drag_on = 1'b1;
		end else if (flex_start != 0) begin
			held = now - flex_start;
			since_click = now - prev_click;
			if (!drag_on && held >= 32'(gamr_pkg::HOLD_SHORT_MS) &&
					since_click >= 32'(gamr_pkg::REFRACTORY_MS)) begin
				lb = 1'b1;
				prev_click = now;
			end
			drag_on = 1'b0;
			flex_start = '0;
		end
		if (drag_on)
			lb = 1'b1;

		if (it == gamr_pkg::MUSCLE_EXT) begin
			if (ext_start == 0)
				ext_start = now;
			held = now - ext_start;
			if (held >= 32'(gamr_pkg::HOLD_LONG_MS)) begin
				wheel = clip127((-ay) / gamr_pkg::SCROLL_DIV);
				dy = 0;
			end
		end else if (ext_start != 0) begin
			held = now - ext_start;
			since_click = now - prev_click;
			if (held >= 32'(gamr_pkg::HOLD_SHORT_MS) && held < 32'(gamr_pkg::HOLD_LONG_MS) &&
					since_click >= 32'(gamr_pkg::REFRACTORY_MS)) begin
				rb = 1'b1;
				prev_click = now;
			end
			ext_start = '0;
		end

		rep.mx = gamr_pkg::MOVE_W'(dx);
		rep.my = gamr_pkg::MOVE_W'(dy);
		rep.sc = gamr_pkg::MOVE_W'(wheel);
		rep.lb = lb;
		rep.rb = rb;
		return rep;
	endfunction

	function automatic logic sender_pauses();
		case (idle_mode)
			IDLE_SENDER: return $urandom_range(0, 99) < 84;
			IDLE_BOTH:   return $urandom_range(0, 99) < 15;
			default:     return 1'b0;
		endcase
	endfunction

	function automatic logic receiver_pauses();
		case (idle_mode)
			IDLE_RECEIVER: return $urandom_range(0, 99) < 84;
			IDLE_BOTH:     return $urandom_range(0, 99) < 15;
			default:       return 1'b0;
		endcase
	endfunction

	function automatic logic signed [gamr_pkg::RATE_W-1:0] pick_rate();
		int v;
		case ($urandom_range(0, 4))
			0: v = int'($urandom_range(0, 65535)) - 32768;
			1: v = int'($urandom_range(0, 600)) - 300;
			2: v = int'(dz_level) + int'($urandom_range(0, 4)) - 2;
			3: begin
				case ($urandom_range(0, 3))
					0: v = -32768;
					1: v = 32767;
					2: v = 0;
					default: v = -1;
				endcase
			end
			default: v = gamr_pkg::SCROLL_SAT_MAG + int'($urandom_range(0, 60)) - 30;
		endcase
		if ($urandom_range(0, 1) && v > -32768)
			v = -v;
		if (v > 32767)
			v = 32767;
		return gamr_pkg::RATE_W'(v);
	endfunction

	task automatic send_frame(gamr_pkg::muscle_t it, logic [31:0] t,
			logic [gamr_pkg::LEVEL_W-1:0] fl, logic signed [gamr_pkg::RATE_W-1:0] yaw,
			logic signed [gamr_pkg::RATE_W-1:0] pitch, logic typed, report_t typed_rep);
		report_t rep;
		while (sender_pauses()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		intent       <= it;
		time_ms      <= t;
		flexor_level <= fl;
		yaw_rate     <= yaw;
		pitch_rate   <= pitch;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		rep = predict_report(it, t, fl, yaw, pitch);
		if (typed)
			rep = typed_rep;
		report_q.push_back(rep);
	endtask

	task automatic drain_reports();
		while (report_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_settings(int lo, int hi, int dz, int g);
		drain_reports();
		cfg_we    <= 1'b1;
		cfg_index <= gamr_pkg::CFG_CLUTCH_LOW;
		cfg_data  <= gamr_pkg::CFG_DATA_W'(lo);
		@(posedge clk);
		cfg_index <= gamr_pkg::CFG_CLUTCH_HIGH;
		cfg_data  <= gamr_pkg::CFG_DATA_W'(hi);
		@(posedge clk);
		cfg_index <= gamr_pkg::CFG_DEADZONE;
		cfg_data  <= gamr_pkg::CFG_DATA_W'(dz);
		@(posedge clk);
		cfg_index <= gamr_pkg::CFG_GAIN;
		cfg_data  <= gamr_pkg::CFG_DATA_W'(g);
		@(posedge clk);
		cfg_we    <= 1'b0;
		clutch_lo = gamr_pkg::LEVEL_W'(lo);
		clutch_hi = gamr_pkg::LEVEL_W'(hi);
		dz_level  = gamr_pkg::DEADZONE_W'(dz);
		gain      = gamr_pkg::GAIN_W'(g);
	endtask

	task automatic run_gesture_stream(int count);
		logic [gamr_pkg::LEVEL_W-1:0] fl;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 49))
				0: stream_time = $urandom;
				1: stream_time = 32'hffff_ff00 + $urandom_range(0, 255);
				2: stream_time = '0;
				3, 4, 5: stream_time += $urandom_range(200, 700);
				default: stream_time += $urandom_range(0, 160);
			endcase
			if ($urandom_range(0, 99) < 28)
				stream_intent = gamr_pkg::muscle_t'($urandom_range(0, 3));
			if ($urandom_range(0, 1))
				fl = gamr_pkg::LEVEL_W'($urandom_range(clutch_lo, clutch_hi));
			else
				fl = gamr_pkg::LEVEL_W'($urandom);
			send_frame(stream_intent, stream_time, fl, pick_rate(), pick_rate(), 1'b0, REP_ZERO);
		end
		in_valid <= 1'b0;
	endtask

	// receiver side, with one long hold-off to back the block up
	always @(posedge clk) begin
		if (pressure_req && !pressure_done) begin
			hold_cnt = PRESSURE_CYCLES;
			pressure_done = 1'b1;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= receiver_pauses();
		end
	end

	always @(posedge clk) begin
		report_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (report_q.size() == 0) begin
				$error("report transfer with nothing expected");
				fail_count++;
			end else begin
				want = report_q.pop_front();
				if (move_x !== want.mx) begin
					$error("move_x expected %0d got %0d", want.mx, move_x);
					fail_count++;
				end
				if (move_y !== want.my) begin
					$error("move_y expected %0d got %0d", want.my, move_y);
					fail_count++;
				end
				if (scroll !== want.sc) begin
					$error("scroll expected %0d got %0d", want.sc, scroll);
					fail_count++;
				end
				if (left_button !== want.lb) begin
					$error("left_button expected %0b got %0b", want.lb, left_button);
					fail_count++;
				end
				if (right_button !== want.rb) begin
					$error("right_button expected %0b got %0b", want.rb, right_button);
					fail_count++;
				end
			end
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++)
			send_frame(DIR_ROWS[i].it, DIR_ROWS[i].t, DIR_ROWS[i].fl, DIR_ROWS[i].yaw,
				DIR_ROWS[i].pitch, DIR_ROWS[i].typed, DIR_ROWS[i].rep);
		in_valid <= 1'b0;

		apply_settings(100, 2000, 40, 384);
		idle_mode = IDLE_NONE;
		run_gesture_stream(ITEMS_PER_PHASE);

		// out-of-order clutch levels, widest deadzone and gain
		apply_settings(4095, 0, 32767, 65535);
		idle_mode = IDLE_SENDER;
		run_gesture_stream(ITEMS_PER_PHASE);

		apply_settings(0, 4095, 0, 0);
		idle_mode = IDLE_RECEIVER;
		pressure_req = 1'b1;
		run_gesture_stream(ITEMS_PER_PHASE);

		// no level lies strictly between the clutch levels
		apply_settings(1000, 1001, 1, 1);
		idle_mode = IDLE_BOTH;
		run_gesture_stream(ITEMS_PER_PHASE);

		apply_settings($urandom_range(0, 4095), $urandom_range(0, 4095),
			$urandom_range(0, 3000), $urandom_range(0, 65535));
		idle_mode = IDLE_NONE;
		run_gesture_stream(ITEMS_PER_PHASE);

		apply_settings(500, 3000, 200, 256);
		idle_mode = IDLE_BOTH;
		run_gesture_stream(ITEMS_PER_PHASE);

		drain_reports();
		repeat (6) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
